>>> hw/rtl/bfe_pkg.sv
// Shared widths and constants of the feedback echo delay.
package bfe_pkg;

  localparam int unsigned SampleW     = 32;
  localparam int unsigned KnobW       = 12;
  localparam int unsigned InDataW     = 48;
  localparam int unsigned OutDataW    = 32;
  localparam int unsigned KnobDivisor = 4100;
  localparam int unsigned DelayShift  = 25;

  typedef logic signed [SampleW-1:0] sample_t;

endpackage

>>> hw/rtl/bfe_ring.sv
// Echo ring store: one write port and one registered read port.
module bfe_ring #(
  parameter int unsigned Depth = 2304,
  parameter int unsigned AddrW = 12
) (
  input  logic               clk_i,
  input  logic               rd_en_i,
  input  logic [AddrW-1:0]   rd_addr_i,
  output bfe_pkg::sample_t   rd_data_o,
  input  logic               wr_en_i,
  input  logic [AddrW-1:0]   wr_addr_i,
  input  bfe_pkg::sample_t   wr_data_i
);

  bfe_pkg::sample_t mem_q [Depth];
  bfe_pkg::sample_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/block_feedback_echo.sv
// Feedback echo delay: top level with position tracking, ring access and output register.
//
// Usage: the slave stream carries one audio item per transfer, tdata holding the
// signed Q31 sample and the 12-bit delay knob. The master stream returns one echo
// sample per input item, in order. Samples are grouped into blocks of
// BLOCK_SAMPLES; the ring keeps NUM_STEPS-1 blocks. The knob is sampled at the
// first item of each block and selects a delay of 1..NUM_STEPS-1 blocks.
// Path: an accepted item is loaded into the input register at the accepting edge,
// then passes the registered ring read, then the output register.
// Throughput: one item per cycle while the receiver takes results, set by
// the single read and single write of the ring per item; a result written into
// the ring is forwarded when the very next item reads it.
// Reset: position and fill count are cleared and the delay set to one block at once;
// the ring memory itself is not swept. Entries not yet written since reset read as zero
// through the fill count, so items are accepted from the first cycle after reset.
// Stall: when m_axis_tready is low the output register holds, the pipeline fills
// up to three items and then s_axis_tready drops until the receiver takes one.
module block_feedback_echo #(
  parameter int unsigned NUM_STEPS     = 10,
  parameter int unsigned BLOCK_SAMPLES = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] sample, [43:32] delay_knob, [47:44] zero
  input  logic [bfe_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] echo_sample
  output logic [bfe_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned Ring   = NUM_STEPS - 1;
  localparam int unsigned Depth  = Ring * BLOCK_SAMPLES;
  localparam int unsigned SlotW  = (Ring > 1) ? $clog2(Ring) : 1;
  localparam int unsigned OffW   = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW  = $clog2(Depth + 1);
  localparam int unsigned DelayW = $clog2(Ring + 1);
  localparam int unsigned PsW    = DelayW + 1;
  localparam longint unsigned DelayMul =
      ((longint'(Ring) << bfe_pkg::DelayShift) + bfe_pkg::KnobDivisor - 1)
      / bfe_pkg::KnobDivisor;
  localparam int unsigned MulW   = $clog2(DelayMul + 1);
  localparam int unsigned ProdW  = bfe_pkg::KnobW + MulW;

  // input stage
  logic                      a_valid_q;
  bfe_pkg::sample_t          a_x_q;
  logic [DelayW-1:0]         a_dk_q;
  // ring read stage
  logic                      b_valid_q;
  bfe_pkg::sample_t          b_x_q;
  logic [AddrW-1:0]          b_wr_q;
  logic                      b_zero_q;
  logic                      b_fwd_q;
  // output stage
  logic                      out_valid_q;
  bfe_pkg::sample_t          out_y_q;
  bfe_pkg::sample_t          last_y_q;
  // position state
  logic [SlotW-1:0]          slot_q;
  logic [OffW-1:0]           off_q;
  logic [AddrW-1:0]          wr_base_q;
  logic [DelayW-1:0]         delay_q;
  logic [FillW-1:0]          fill_q;

  logic                      in_fire;
  logic                      a_move;
  logic                      b_move;
  logic [ProdW-1:0]          dk_prod;
  logic [DelayW-1:0]         dk_d;
  logic [DelayW-1:0]         d_cur;
  logic [PsW-1:0]            ps_sum;
  logic [PsW-1:0]            prev_slot;
  logic [AddrW-1:0]          rd_idx;
  logic [AddrW-1:0]          wr_idx;
  logic                      rd_fwd;
  logic                      rd_zero;
  logic                      blk_end;
  bfe_pkg::sample_t          ring_rd;
  bfe_pkg::sample_t          old_y;
  bfe_pkg::sample_t          y;

  assign b_move        = b_valid_q && (!out_valid_q || m_axis_tready);
  assign a_move        = a_valid_q && (!b_valid_q || b_move);
  assign s_axis_tready = !a_valid_q || a_move;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // delay candidate: knob * Ring / 4100 + 1 by reciprocal multiply
  assign dk_prod = ProdW'(s_axis_tdata[bfe_pkg::SampleW +: bfe_pkg::KnobW])
                 * ProdW'(DelayMul);
  assign dk_d    = DelayW'(dk_prod >> bfe_pkg::DelayShift) + DelayW'(1);

  always_comb begin
    d_cur     = (off_q == '0) ? a_dk_q : delay_q;
    ps_sum    = PsW'(slot_q) + PsW'(Ring) - PsW'(d_cur);
    prev_slot = (ps_sum >= PsW'(Ring)) ? (ps_sum - PsW'(Ring)) : ps_sum;
    rd_idx    = AddrW'(prev_slot) * AddrW'(BLOCK_SAMPLES) + AddrW'(off_q);
    wr_idx    = wr_base_q + AddrW'(off_q);
    rd_zero   = !(FillW'(rd_idx) < fill_q);
    rd_fwd    = b_move && (rd_idx == b_wr_q);
    blk_end   = (off_q == OffW'(BLOCK_SAMPLES - 1));
  end

  always_comb begin
    if (b_fwd_q) begin
      old_y = last_y_q;
    end else if (b_zero_q) begin
      old_y = '0;
    end else begin
      old_y = ring_rd;
    end
    y = (b_x_q >>> 1) + (old_y >>> 1);
  end

  bfe_ring #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ring (
    .clk_i     (clk_i),
    .rd_en_i   (a_move),
    .rd_addr_i (rd_idx),
    .rd_data_o (ring_rd),
    .wr_en_i   (b_move),
    .wr_addr_i (b_wr_q),
    .wr_data_i (y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      slot_q      <= '0;
      off_q       <= '0;
      wr_base_q   <= '0;
      delay_q     <= DelayW'(1);
      fill_q      <= '0;
    end else begin
      if (s_axis_tready) begin
        a_valid_q <= s_axis_tvalid;
      end
      if (!b_valid_q || b_move) begin
        b_valid_q <= a_move;
      end
      if (!out_valid_q || m_axis_tready) begin
        out_valid_q <= b_move;
      end
      if (a_move) begin
        if (off_q == '0) begin
          delay_q <= a_dk_q;
        end
        if (fill_q != FillW'(Depth)) begin
          fill_q <= fill_q + FillW'(1);
        end
        if (blk_end) begin
          off_q <= '0;
          if (slot_q == SlotW'(Ring - 1)) begin
            slot_q    <= '0;
            wr_base_q <= '0;
          end else begin
            slot_q    <= slot_q + SlotW'(1);
            wr_base_q <= wr_base_q + AddrW'(BLOCK_SAMPLES);
          end
        end else begin
          off_q <= off_q + OffW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_x_q  <= s_axis_tdata[bfe_pkg::SampleW-1:0];
      a_dk_q <= dk_d;
    end
    if (a_move) begin
      b_x_q    <= a_x_q;
      b_wr_q   <= wr_idx;
      b_zero_q <= rd_zero;
      b_fwd_q  <= rd_fwd;
    end
    if (b_move) begin
      out_y_q  <= y;
      last_y_q <= y;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_y_q;

  a_fwd_written : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && b_fwd_q |-> !b_zero_q)
    else $error("forwarded read marked as unwritten entry");

  a_block_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_move && blk_end |=> off_q == '0)
    else $error("offset did not wrap at block end");

  a_base_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_base_q == AddrW'(slot_q) * AddrW'(BLOCK_SAMPLES))
    else $error("write base out of step with block slot");

  a_delay_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_move |-> d_cur >= DelayW'(1) && d_cur <= DelayW'(Ring))
    else $error("delay outside of ring length");

endmodule

>>> tb/tb_top.sv
// Testbench of the feedback echo delay: stream driver, echo predictor and result checker.
module tb_top;
  localparam int unsigned SampleW       = bfe_pkg::SampleW;
  localparam int unsigned KnobW         = bfe_pkg::KnobW;
  localparam int unsigned InDataW       = bfe_pkg::InDataW;
  localparam int unsigned OutDataW      = bfe_pkg::OutDataW;
  localparam int unsigned KnobDivisor   = bfe_pkg::KnobDivisor;
  typedef bfe_pkg::sample_t sample_t;

  localparam int unsigned NumSteps      = 10;
  localparam int unsigned BlockSamples  = 256;
  localparam int unsigned RingBlocks    = NumSteps - 1;
  localparam int unsigned StoreDepth    = RingBlocks * BlockSamples;
  localparam int unsigned RandItems     = 1750;
  localparam int unsigned DirItems      = 24;
  localparam int unsigned PhaseItems    = 600;
  localparam int unsigned HoldOffAt     = 1300;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned ReportLimit   = 100;
  localparam int unsigned KnobMax       = (1 << KnobW) - 1;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [31:0] sample, [43:32] delay_knob, [47:44] zero
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [31:0] echo_sample
  logic [OutDataW-1:0] m_axis_tdata;

  logic [InDataW-1:0] sample_queue [$];
  sample_t            echo_due [$];

  sample_t     echo_mem [StoreDepth];
  int unsigned ring_slot;
  int unsigned blk_offset;
  int unsigned delay_len;

  int unsigned items_in      = 0;
  int unsigned results_out   = 0;
  int unsigned total_items   = 0;
  int unsigned cycle_count   = 0;
  int unsigned holdoff_left  = 0;
  int unsigned error_count   = 0;
  bit          holdoff_done  = 1'b0;
  bit          failed        = 1'b0;
  sample_t     echo_want;

  block_feedback_echo #(
    .NUM_STEPS    (NumSteps),
    .BLOCK_SAMPLES(BlockSamples)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic sample_t echo_predict(sample_t x, logic [KnobW-1:0] knob);
    int unsigned rd_slot;
    int unsigned rd_idx;
    int unsigned wr_idx;
    sample_t     y;
    if (blk_offset == 0) begin
      delay_len = (int'(knob) * RingBlocks) / KnobDivisor + 1;
    end
    rd_slot = (ring_slot + RingBlocks - delay_len) % RingBlocks;
    rd_idx  = rd_slot * BlockSamples + blk_offset;
    wr_idx  = ring_slot * BlockSamples + blk_offset;
    // read the old entry before the new one overwrites it
    y = (x >>> 1) + (echo_mem[rd_idx] >>> 1);
    echo_mem[wr_idx] = y;
    blk_offset++;
    if (blk_offset >= BlockSamples) begin
      blk_offset = 0;
      ring_slot  = (ring_slot + 1) % RingBlocks;
    end
    return y;
  endfunction

  function automatic logic [InDataW-1:0] pack_item(sample_t s, logic [KnobW-1:0] k);
    return {{(InDataW - SampleW - KnobW){1'b0}}, k, s};
  endfunction

  // idle share in percent: sender light then heavy, receiver the other way round
  function automatic int unsigned idle_share(bit receiver);
    if (items_in < PhaseItems) begin
      return receiver ? 79 : 30;
    end else if (items_in < 2 * PhaseItems) begin
      return receiver ? 30 : 79;
    end
    return 0;
  endfunction

  function automatic logic [KnobW-1:0] block_knob();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return KnobW'(KnobMax);
      2: return KnobW'(3645);
      3: return KnobW'(3644);
      4: return KnobW'(456);
      default: return KnobW'($urandom_range(0, KnobMax));
    endcase
  endfunction

  initial begin
    sample_t          dir_samples [12];
    sample_t          s;
    logic [KnobW-1:0] k;
    int unsigned      style;
    int unsigned      pos;
    dir_samples = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000, 32'shFFFFFFFF,
                    32'sh00000001, 32'shFFFFFFFE, 32'sh40000000, 32'shC0000000,
                    32'sh3FFFFFFF, 32'shBFFFFFFF, 32'sh00000003, 32'sh80000001};
    foreach (echo_mem[i]) echo_mem[i] = '0;
    ring_slot  = 0;
    blk_offset = 0;
    delay_len  = 1;
    style      = 0;
    // first item opens a block at full delay; knobs alternate between extremes
    for (int i = 0; i < DirItems; i++) begin
      k = (i % 2 == 0) ? KnobW'(KnobMax) : '0;
      sample_queue.push_back(pack_item(dir_samples[i % 12], k));
    end
    for (int i = 0; i < RandItems; i++) begin
      pos = sample_queue.size();
      if (pos % BlockSamples == 0) begin
        k     = block_knob();
        style = $urandom_range(0, 4);
      end else begin
        k = KnobW'($urandom_range(0, KnobMax));
      end
      case (style)
        1: s = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
        2: s = sample_t'($urandom_range(0, 255)) - 32'sd128;
        3: s = $urandom_range(0, 1) ? sample_t'($urandom) | 32'sh40000000
                                    : sample_t'($urandom) & 32'shBFFFFFFF;
        default: s = sample_t'($urandom);
      endcase
      sample_queue.push_back(pack_item(s, k));
    end
    total_items = sample_queue.size();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (items_in == total_items && echo_due.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (!failed && echo_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        echo_due.push_back(echo_predict(s_axis_tdata[SampleW-1:0],
                                        s_axis_tdata[SampleW +: KnobW]));
        items_in++;
      end
      // advance to the next item only once the current one is taken
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_queue.size() != 0 && $urandom_range(0, 99) >= idle_share(1'b0)) begin
          s_axis_tdata  <= sample_queue.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_out++;
        if (echo_due.size() == 0) begin
          failed = 1'b1;
          error_count++;
          if (error_count <= ReportLimit) begin
            $error("echo_sample: expected none, actual %0d", $signed(m_axis_tdata));
          end
        end else begin
          echo_want = echo_due.pop_front();
          if (m_axis_tdata !== echo_want) begin
            failed = 1'b1;
            error_count++;
            if (error_count <= ReportLimit) begin
              $error("echo_sample: expected %0d, actual %0d", echo_want,
                     $signed(m_axis_tdata));
            end
          end
        end
      end
      // hold off once for a long stretch so the block fills and stalls its input
      if (holdoff_left != 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else if (!holdoff_done && results_out >= HoldOffAt) begin
        holdoff_done = 1'b1;
        holdoff_left = HoldOffCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= idle_share(1'b1));
      end
    end
  end

endmodule
